// ===== sv/mft_pkg.sv =====
// Shared types and constants of the management-frame rate threat tracker.
// Used by the item channels, the top level, the configuration registers and the testbench; depends on nothing.
`timescale 1ns / 1ps

package mft_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = 5;
  localparam int MAC_W = 48;

  localparam logic [31:0] MIN_ELAPSED = 32'd100;
  localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [31:0] CNT32_MAX = 32'hFFFF_FFFF;
  localparam logic [5:0] THREAT_MAX = 6'd63;

  localparam logic [1:0] FTYPE_MGMT = 2'd0;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_PROBE = 4'd4;
  localparam logic [3:0] SUB_DEAUTH = 4'd12;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BEACON = 2'd1;
  localparam logic [1:0] KIND_DEAUTH = 2'd2;
  localparam logic [1:0] KIND_PROBE = 2'd3;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] CFG_BEACON_LIMIT = 3'd0;
  localparam logic [2:0] CFG_PROBE_LIMIT = 3'd1;
  localparam logic [2:0] CFG_DEAUTH_LIMIT = 3'd2;
  localparam logic [2:0] CFG_ALARM_LEVEL = 3'd3;
  localparam logic [2:0] CFG_WINDOW_LEN = 3'd4;
  localparam logic [2:0] CFG_STALE_AFTER = 3'd5;

  // Steps of the shared multiplier while one slot is scored.
  localparam logic [2:0] MUL_BTW = 3'd0;
  localparam logic [2:0] MUL_RBT = 3'd1;
  localparam logic [2:0] MUL_BRL = 3'd2;
  localparam logic [2:0] MUL_DRL = 3'd3;
  localparam logic [2:0] MUL_PRL = 3'd4;
  localparam logic [2:0] MUL_DONE = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRD,
    S_FCMP,
    S_FEMIT,
    S_TRD,
    S_TWAIT,
    S_TMUL,
    S_TEMIT
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [47:0] source_mac;
    logic [7:0]  frame_control;
    logic [11:0] frame_length;
    logic        is_management;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  entry_index;
    logic        entry_valid;
    logic [47:0] entry_mac;
    logic [4:0]  risk_score;
    logic [1:0]  threat_kind;
    logic        newly_malicious;
    logic        is_malicious;
    logic [5:0]  threat_total;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  beacon_rate_limit;
    logic [7:0]  probe_rate_limit;
    logic [7:0]  deauth_rate_limit;
    logic [4:0]  risk_alarm_level;
    logic [15:0] window_length_ms;
    logic [15:0] stale_after_ms;
  } cfg_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [31:0] window_start;
    logic [31:0] beacon_total;
    logic [15:0] recent_beacons;
    logic [15:0] recent_probes;
    logic [15:0] recent_deauths;
    logic [1:0]  kind;
    logic        malicious;
  } entry_t;

endpackage

// ===== sv/mft_in_if.sv =====
// Input item channel of the threat tracker.
// Depends on mft_pkg for the item type.
`timescale 1ns / 1ps

interface mft_in_if;
  logic valid;
  logic ready;
  mft_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/mft_out_if.sv =====
// Result item channel of the threat tracker.
// Depends on mft_pkg for the result type.
`timescale 1ns / 1ps

interface mft_out_if;
  logic valid;
  logic ready;
  mft_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/mft_cfg_if.sv =====
// Configuration write channel of the threat tracker.
// Stands alone; the index codes live in mft_pkg.
`timescale 1ns / 1ps

interface mft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== sv/mgmt_frame_rate_threat_tracker_core.sv =====
// Top level of the management-frame rate threat tracker.
// Depends on mft_pkg, the three channel interfaces, mft_cfg_regs, mft_ram and mft_mul.
`timescale 1ns / 1ps

// Usage:
// frame_in carries one item per transfer: a received frame (operation 0) or an
// analysis tick (operation 1). result_out returns one result for a frame and
// one result per used table slot for a tick (one empty result if no slot is
// used); the final result of an item has last_result set. cfg writes the six
// limit registers, one per transfer, and is always ready.
// The table lives in one RAM read one slot at a time. A frame that is looked up
// is accepted, then read and compared slot by slot until its MAC matches or the
// last slot is reached, then emitted; a dropped frame goes straight to its result.
// A tick is accepted, skips each unused slot and takes each used slot through a
// read, a wait, the five products that share one multiplier and an emit.
// frame_in is ready only while no item is in work. A result register sits on
// result_out, so the next item is taken while a result waits; when the
// receiver stalls, the sequencer holds before emitting its next result.
// Reset (synchronous) marks every slot free, clears the threat count and loads
// the default limits; no clearing pass is needed.
module mgmt_frame_rate_threat_tracker_core (
  input  logic     clk,
  input  logic     rst,
  mft_in_if.sink   frame_in,
  mft_out_if.source result_out,
  mft_cfg_if.sink  cfg
);

  localparam logic [mft_pkg::IDX_W-1:0] LAST_IDX = mft_pkg::IDX_W'(mft_pkg::TABLE_DEPTH - 1);

  mft_pkg::state_t state, state_next;
  mft_pkg::cfg_t regs;
  mft_pkg::in_item_t item;
  mft_pkg::out_item_t out_q, fres;
  mft_pkg::entry_t rdata, wentry, fentry, tentry;

  logic [mft_pkg::TABLE_DEPTH-1:0] slot_used;
  logic [mft_pkg::IDX_W-1:0] idx, hit_idx, free_idx, waddr;
  logic hit, free_found, out_valid_q;
  logic [5:0] mal_count;
  logic [31:0] w_q, t_q, mul_a, mul_b;
  logic [63:0] prod, btw_q;
  logic [2:0] step;
  logic stale_q, restart_q;
  logic c1, c2, c3, c4, c5, c6;

  logic in_ready, ram_re, ram_we, out_load, frame_ok, match, more_used;
  logic [31:0] d_ws, d_fs, d_ls;
  logic [26:0] rb1000, rp1000, rd1000, rb2000;
  logic [35:0] w10, w8, w3;
  logic [17:0] recent_sum;
  logic [4:0] risk;
  logic [1:0] kind_new;
  logic newly;
  logic [5:0] mal_inc;
  logic [3:0] sub;

  mft_cfg_regs u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  mft_ram #(.WIDTH($bits(mft_pkg::entry_t)), .DEPTH(mft_pkg::TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(wentry),
    .re(ram_re), .raddr(idx), .rdata(rdata)
  );

  mft_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  assign frame_in.ready = in_ready;
  assign result_out.valid = out_valid_q;
  assign result_out.data = out_q;

  assign frame_ok = frame_in.data.is_management &&
                    (frame_in.data.frame_length >= mft_pkg::MIN_FRAME_LEN);
  assign match = slot_used[idx] && (rdata.mac == item.source_mac);
  assign sub = item.frame_control[7:4];

  // Any used slot beyond the current one decides whether this result is last.
  always_comb begin
    more_used = 1'b0;
    for (int j = 0; j < mft_pkg::TABLE_DEPTH; j++) begin
      if (mft_pkg::IDX_W'(j) > idx && slot_used[j]) begin
        more_used = 1'b1;
      end
    end
  end

  // Elapsed times and constant-scaled rates of the entry in the read register.
  assign d_ws = item.now_ms - rdata.window_start;
  assign d_fs = item.now_ms - rdata.first_seen;
  assign d_ls = item.now_ms - rdata.last_seen;
  assign rb1000 = 27'(rdata.recent_beacons) * 27'd1000;
  assign rp1000 = 27'(rdata.recent_probes) * 27'd1000;
  assign rd1000 = 27'(rdata.recent_deauths) * 27'd1000;
  assign rb2000 = 27'(rdata.recent_beacons) * 27'd2000;
  assign w10 = 36'(w_q) * 36'd10;
  assign w8 = {1'b0, w_q, 3'b000};
  assign w3 = 36'(w_q) * 36'd3;
  assign recent_sum = 18'(rdata.recent_beacons) + 18'(rdata.recent_probes)
                    + 18'(rdata.recent_deauths);
  assign c5 = (36'(rb1000) > w10) || (36'(rp1000) > w8) || (rdata.recent_beacons > 16'd20);
  assign c6 = recent_sum > 18'd15;

  always_comb begin
    case (step)
      mft_pkg::MUL_BTW: begin mul_a = rdata.beacon_total; mul_b = w_q; end
      mft_pkg::MUL_RBT: begin mul_a = 32'(rdata.recent_beacons); mul_b = t_q; end
      mft_pkg::MUL_BRL: begin mul_a = 32'(regs.beacon_rate_limit); mul_b = w_q; end
      mft_pkg::MUL_DRL: begin mul_a = 32'(regs.deauth_rate_limit); mul_b = w_q; end
      mft_pkg::MUL_PRL: begin mul_a = 32'(regs.probe_rate_limit); mul_b = w_q; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  // Scoring outcome of the slot in work.
  always_comb begin
    risk = 5'd0;
    kind_new = rdata.kind;
    if (!stale_q) begin
      risk = (c1 ? 5'd4 : 5'd0) + (c2 ? 5'd3 : 5'd0) + (c3 ? 5'd5 : 5'd0)
           + (c4 ? 5'd4 : 5'd0) + (c5 ? 5'd2 : 5'd0) + (c6 ? 5'd2 : 5'd0);
      if (c1) kind_new = mft_pkg::KIND_BEACON;
      if (c2 && kind_new == mft_pkg::KIND_NONE) kind_new = mft_pkg::KIND_BEACON;
      if (c3) kind_new = mft_pkg::KIND_DEAUTH;
      if (c4) kind_new = mft_pkg::KIND_PROBE;
    end
    newly = !stale_q && (risk >= regs.risk_alarm_level) && !rdata.malicious;
    mal_inc = (mal_count < mft_pkg::THREAT_MAX) ? mal_count + 6'd1 : mal_count;
  end

  // Entry written back for a counted frame.
  always_comb begin
    if (hit) begin
      fentry = rdata;
    end else begin
      fentry = '0;
      fentry.mac = item.source_mac;
      fentry.first_seen = item.now_ms;
      fentry.window_start = item.now_ms;
    end
    fentry.last_seen = item.now_ms;
    if (item.frame_control[3:2] == mft_pkg::FTYPE_MGMT) begin
      case (sub)
        mft_pkg::SUB_BEACON: begin
          if (fentry.beacon_total != mft_pkg::CNT32_MAX) begin
            fentry.beacon_total = fentry.beacon_total + 32'd1;
          end
          if (fentry.recent_beacons != mft_pkg::CNT16_MAX) begin
            fentry.recent_beacons = fentry.recent_beacons + 16'd1;
          end
        end
        mft_pkg::SUB_PROBE: begin
          if (fentry.recent_probes != mft_pkg::CNT16_MAX) begin
            fentry.recent_probes = fentry.recent_probes + 16'd1;
          end
        end
        mft_pkg::SUB_DEAUTH: begin
          if (fentry.recent_deauths != mft_pkg::CNT16_MAX) begin
            fentry.recent_deauths = fentry.recent_deauths + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result of a frame, or of a tick on an empty table.
  always_comb begin
    fres = '0;
    fres.threat_total = mal_count;
    fres.last_result = 1'b1;
    if (hit || free_found) begin
      fres.entry_index = waddr;
      fres.entry_valid = 1'b1;
      fres.entry_mac = fentry.mac;
      fres.threat_kind = fentry.kind;
      fres.is_malicious = fentry.malicious;
    end
  end

  // Entry written back after a tick has scored the slot.
  always_comb begin
    tentry = rdata;
    tentry.kind = kind_new;
    tentry.malicious = rdata.malicious | newly;
    if (restart_q) begin
      tentry.recent_beacons = 16'd0;
      tentry.recent_probes = 16'd0;
      tentry.recent_deauths = 16'd0;
      tentry.window_start = item.now_ms;
    end
  end

  assign wentry = (state == mft_pkg::S_TEMIT) ? tentry : fentry;
  assign waddr = (state == mft_pkg::S_TEMIT) ? idx : (hit ? hit_idx : free_idx);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mft_pkg::S_IDLE: begin
        if (frame_in.valid) begin
          if (frame_in.data.operation == mft_pkg::OP_TICK) begin
            state_next = (slot_used == '0) ? mft_pkg::S_FEMIT : mft_pkg::S_TRD;
          end else begin
            state_next = frame_ok ? mft_pkg::S_FRD : mft_pkg::S_FEMIT;
          end
        end
      end
      mft_pkg::S_FRD: state_next = mft_pkg::S_FCMP;
      mft_pkg::S_FCMP: begin
        if (match || idx == LAST_IDX) begin
          state_next = mft_pkg::S_FEMIT;
        end else begin
          state_next = mft_pkg::S_FRD;
        end
      end
      mft_pkg::S_FEMIT: begin
        if (out_load) state_next = mft_pkg::S_IDLE;
      end
      mft_pkg::S_TRD: begin
        if (slot_used[idx]) begin
          state_next = mft_pkg::S_TWAIT;
        end else if (idx == LAST_IDX) begin
          state_next = mft_pkg::S_IDLE;
        end
      end
      mft_pkg::S_TWAIT: state_next = mft_pkg::S_TMUL;
      mft_pkg::S_TMUL: begin
        if (step == mft_pkg::MUL_DONE) state_next = mft_pkg::S_TEMIT;
      end
      mft_pkg::S_TEMIT: begin
        if (out_load) begin
          state_next = (more_used && idx != LAST_IDX) ? mft_pkg::S_TRD : mft_pkg::S_IDLE;
        end
      end
      default: state_next = mft_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    ram_re = 1'b0;
    ram_we = 1'b0;
    out_load = 1'b0;
    case (state)
      mft_pkg::S_IDLE: in_ready = 1'b1;
      mft_pkg::S_FRD: ram_re = 1'b1;
      mft_pkg::S_TRD: ram_re = slot_used[idx];
      mft_pkg::S_FEMIT: begin
        out_load = !out_valid_q || result_out.ready;
        ram_we = out_load && (hit || free_found);
      end
      mft_pkg::S_TEMIT: begin
        out_load = !out_valid_q || result_out.ready;
        ram_we = out_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mft_pkg::S_IDLE;
      slot_used <= '0;
      mal_count <= 6'd0;
      out_valid_q <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
      idx <= '0;
      step <= mft_pkg::MUL_BTW;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_out.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        mft_pkg::S_IDLE: begin
          if (frame_in.valid) begin
            item <= frame_in.data;
            idx <= '0;
            hit <= 1'b0;
            free_found <= 1'b0;
          end
        end
        mft_pkg::S_FCMP: begin
          if (match) begin
            hit <= 1'b1;
            hit_idx <= idx;
          end else begin
            if (!slot_used[idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= idx;
            end
            if (idx != LAST_IDX) idx <= idx + 5'd1;
          end
        end
        mft_pkg::S_FEMIT: begin
          if (out_load) begin
            out_q <= fres;
            if (!hit && free_found) slot_used[free_idx] <= 1'b1;
          end
        end
        mft_pkg::S_TRD: begin
          if (!slot_used[idx] && idx != LAST_IDX) idx <= idx + 5'd1;
        end
        mft_pkg::S_TWAIT: begin
          w_q <= (d_ws < mft_pkg::MIN_ELAPSED) ? mft_pkg::MIN_ELAPSED : d_ws;
          t_q <= (d_fs < mft_pkg::MIN_ELAPSED) ? mft_pkg::MIN_ELAPSED : d_fs;
          stale_q <= d_ls > 32'(regs.stale_after_ms);
          restart_q <= d_ws > 32'(regs.window_length_ms);
          step <= mft_pkg::MUL_BTW;
        end
        mft_pkg::S_TMUL: begin
          step <= step + 3'd1;
          case (step)
            mft_pkg::MUL_RBT: btw_q <= prod;
            mft_pkg::MUL_BRL: begin
              c2 <= (btw_q[63:47] == '0) && ({1'b0, prod} > {btw_q, 1'b0})
                    && (36'(rb2000) > w3);
            end
            mft_pkg::MUL_DRL: c1 <= 64'(rb1000) > prod;
            mft_pkg::MUL_PRL: c3 <= 64'(rd1000) > prod;
            mft_pkg::MUL_DONE: c4 <= 64'(rp1000) > prod;
            default: ;
          endcase
        end
        mft_pkg::S_TEMIT: begin
          if (out_load) begin
            out_q.entry_index <= 5'(idx);
            out_q.entry_valid <= 1'b1;
            out_q.entry_mac <= rdata.mac;
            out_q.risk_score <= risk;
            out_q.threat_kind <= kind_new;
            out_q.newly_malicious <= newly;
            out_q.is_malicious <= rdata.malicious | newly;
            out_q.threat_total <= newly ? mal_inc : mal_count;
            out_q.last_result <= !more_used || idx == LAST_IDX;
            if (newly) mal_count <= mal_inc;
            if (idx != LAST_IDX) idx <= idx + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid_q || result_out.ready))
    else $error("result register overwritten while a result waits");

  a_newly_sticky: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.data.newly_malicious) |-> result_out.data.is_malicious)
    else $error("newly malicious result without malicious flag");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (mal_count >= $past(mal_count)))
    else $error("threat count decreased");
`endif

endmodule

// ===== sv/mft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds the per-slot entries of the tracker table; no dependencies.
`timescale 1ns / 1ps

module mft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/mft_cfg_regs.sv =====
// Configuration register file of the threat tracker.
// Depends on mft_pkg and the mft_cfg_if channel.
`timescale 1ns / 1ps

module mft_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  mft_cfg_if.sink       cfg,
  output mft_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.beacon_rate_limit <= 8'd10;
      regs.probe_rate_limit <= 8'd10;
      regs.deauth_rate_limit <= 8'd5;
      regs.risk_alarm_level <= 5'd5;
      regs.window_length_ms <= 16'd5000;
      regs.stale_after_ms <= 16'd30000;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mft_pkg::CFG_BEACON_LIMIT: regs.beacon_rate_limit <= cfg.wdata[7:0];
        mft_pkg::CFG_PROBE_LIMIT:  regs.probe_rate_limit <= cfg.wdata[7:0];
        mft_pkg::CFG_DEAUTH_LIMIT: regs.deauth_rate_limit <= cfg.wdata[7:0];
        mft_pkg::CFG_ALARM_LEVEL:  regs.risk_alarm_level <= cfg.wdata[4:0];
        mft_pkg::CFG_WINDOW_LEN:   regs.window_length_ms <= cfg.wdata;
        mft_pkg::CFG_STALE_AFTER:  regs.stale_after_ms <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/mft_mul.sv =====
// Shared 32 by 32 multiplier with a registered product.
// Used in turn for the five variable products of the scoring; no dependencies.
`timescale 1ns / 1ps

module mft_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the management-frame rate threat tracker.
// Depends on mft_pkg, the three channel interfaces and the tracker top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mft_in_if  frame_in();
  mft_out_if result_out();
  mft_cfg_if cfg();

  mgmt_frame_rate_threat_tracker_core dut (
    .clk(clk),
    .rst(rst),
    .frame_in(frame_in),
    .result_out(result_out),
    .cfg(cfg)
  );

  always #5 clk = ~clk;

  // Tracker model state.
  mft_pkg::cfg_t      limits;
  mft_pkg::entry_t    table_q [mft_pkg::TABLE_DEPTH];
  logic               used_q [mft_pkg::TABLE_DEPTH];
  logic [5:0]         threat_count;

  mft_pkg::in_item_t  pending_items [$];
  mft_pkg::out_item_t awaited_results [$];

  logic [31:0] clock_ms;
  logic [47:0] mac_pool [40];

  int  mismatches = 0;
  int  results_seen = 0;
  int  ticks_sent = 0;
  int  frames_sent = 0;
  int  idle_cycles = 0;
  bit  in_busy = 0;
  bit  in_fire, out_fire;
  bit  calm = 0;
  int  hold_gen = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  send_gap = 0;
  int  recv_stall = 0;

  function automatic void add_item(mft_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void add_result(mft_pkg::out_item_t r);
    awaited_results = {awaited_results, r};
  endfunction

  function automatic logic [31:0] floored(logic [31:0] now, logic [31:0] then);
    logic [31:0] d;
    d = now - then;
    return (d < mft_pkg::MIN_ELAPSED) ? mft_pkg::MIN_ELAPSED : d;
  endfunction

  function automatic mft_pkg::out_item_t empty_result();
    mft_pkg::out_item_t r;
    r = '0;
    r.threat_total = threat_count;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic logic [4:0] score_entry(int s, logic [31:0] now, output logic newly);
    logic [63:0] w, t, rb, rp, rd, btw;
    logic [31:0] since_seen;
    logic [4:0] risk;
    w = 64'(floored(now, table_q[s].window_start));
    t = 64'(floored(now, table_q[s].first_seen));
    rb = 64'(table_q[s].recent_beacons);
    rp = 64'(table_q[s].recent_probes);
    rd = 64'(table_q[s].recent_deauths);
    btw = 64'(table_q[s].beacon_total) * w;
    risk = 5'd0;
    newly = 1'b0;
    since_seen = now - table_q[s].last_seen;
    if (since_seen > 32'(limits.stale_after_ms)) return 5'd0;
    if (rb * 1000 > 64'(limits.beacon_rate_limit) * w) begin
      risk += 5'd4;
      table_q[s].kind = mft_pkg::KIND_BEACON;
    end
    if (btw < (64'd1 << 47) && rb * t > 2 * btw && rb * 2000 > 3 * w) begin
      risk += 5'd3;
      if (table_q[s].kind == mft_pkg::KIND_NONE) table_q[s].kind = mft_pkg::KIND_BEACON;
    end
    if (rd * 1000 > 64'(limits.deauth_rate_limit) * w) begin
      risk += 5'd5;
      table_q[s].kind = mft_pkg::KIND_DEAUTH;
    end
    if (rp * 1000 > 64'(limits.probe_rate_limit) * w) begin
      risk += 5'd4;
      table_q[s].kind = mft_pkg::KIND_PROBE;
    end
    if (rb * 1000 > 10 * w || rp * 1000 > 8 * w || rb > 20) risk += 5'd2;
    if (rb + rp + rd > 15) risk += 5'd2;
    if (risk >= limits.risk_alarm_level && !table_q[s].malicious) begin
      table_q[s].malicious = 1'b1;
      if (threat_count < mft_pkg::THREAT_MAX) threat_count++;
      newly = 1'b1;
    end
    return risk;
  endfunction

  function automatic void predict_item(mft_pkg::in_item_t it);
    int slot;
    mft_pkg::out_item_t r;
    mft_pkg::out_item_t batch [$];
    logic newly;
    logic [4:0] risk;
    slot = -1;
    if (it.operation == mft_pkg::OP_FRAME) begin
      if (it.is_management && it.frame_length >= mft_pkg::MIN_FRAME_LEN) begin
        for (int i = 0; i < mft_pkg::TABLE_DEPTH; i++)
          if (slot < 0 && used_q[i] && table_q[i].mac == it.source_mac) slot = i;
        if (slot < 0) begin
          for (int i = 0; i < mft_pkg::TABLE_DEPTH; i++)
            if (slot < 0 && !used_q[i]) slot = i;
          if (slot >= 0) begin
            used_q[slot] = 1'b1;
            table_q[slot] = '0;
            table_q[slot].mac = it.source_mac;
            table_q[slot].first_seen = it.now_ms;
            table_q[slot].window_start = it.now_ms;
          end
        end
      end
      if (slot < 0) begin
        add_result(empty_result());
        return;
      end
      table_q[slot].last_seen = it.now_ms;
      if (it.frame_control[3:2] == mft_pkg::FTYPE_MGMT) begin
        case (it.frame_control[7:4])
          mft_pkg::SUB_BEACON: begin
            if (table_q[slot].beacon_total != mft_pkg::CNT32_MAX)
              table_q[slot].beacon_total++;
            if (table_q[slot].recent_beacons != mft_pkg::CNT16_MAX)
              table_q[slot].recent_beacons++;
          end
          mft_pkg::SUB_PROBE:
            if (table_q[slot].recent_probes != mft_pkg::CNT16_MAX)
              table_q[slot].recent_probes++;
          mft_pkg::SUB_DEAUTH:
            if (table_q[slot].recent_deauths != mft_pkg::CNT16_MAX)
              table_q[slot].recent_deauths++;
          default: ;
        endcase
      end
      r = '0;
      r.entry_index = slot[4:0];
      r.entry_valid = 1'b1;
      r.entry_mac = table_q[slot].mac;
      r.threat_kind = table_q[slot].kind;
      r.is_malicious = table_q[slot].malicious;
      r.threat_total = threat_count;
      r.last_result = 1'b1;
      add_result(r);
    end else begin
      for (int i = 0; i < mft_pkg::TABLE_DEPTH; i++) begin
        if (used_q[i]) begin
          risk = score_entry(i, it.now_ms, newly);
          r = '0;
          r.entry_index = i[4:0];
          r.entry_valid = 1'b1;
          r.entry_mac = table_q[i].mac;
          r.risk_score = risk;
          r.threat_kind = table_q[i].kind;
          r.newly_malicious = newly;
          r.is_malicious = table_q[i].malicious;
          r.threat_total = threat_count;
          batch = {batch, r};
        end
      end
      for (int i = 0; i < mft_pkg::TABLE_DEPTH; i++) begin
        if (used_q[i] &&
            it.now_ms - table_q[i].window_start > 32'(limits.window_length_ms)) begin
          table_q[i].recent_beacons = '0;
          table_q[i].recent_probes = '0;
          table_q[i].recent_deauths = '0;
          table_q[i].window_start = it.now_ms;
        end
      end
      if (batch.size() == 0) begin
        add_result(empty_result());
      end else begin
        batch[batch.size() - 1].last_result = 1'b1;
        foreach (batch[k]) add_result(batch[k]);
      end
    end
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      mft_pkg::CFG_BEACON_LIMIT: limits.beacon_rate_limit = val[7:0];
      mft_pkg::CFG_PROBE_LIMIT:  limits.probe_rate_limit = val[7:0];
      mft_pkg::CFG_DEAUTH_LIMIT: limits.deauth_rate_limit = val[7:0];
      mft_pkg::CFG_ALARM_LEVEL:  limits.risk_alarm_level = val[4:0];
      mft_pkg::CFG_WINDOW_LEN:   limits.window_length_ms = val;
      mft_pkg::CFG_STALE_AFTER:  limits.stale_after_ms = val;
      default: ;
    endcase
  endfunction

  // Monitor and predictor update on the rising edge.
  always @(posedge clk) begin
    mft_pkg::out_item_t want, got;
    in_fire <= frame_in.valid && frame_in.ready;
    out_fire <= result_out.valid && result_out.ready;
    if (!rst) begin
      if ((frame_in.valid && frame_in.ready) || (result_out.valid && result_out.ready)
          || (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (result_out.valid && result_out.ready) begin
        got = result_out.data;
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = awaited_results.pop_front();
          if (got.entry_index !== want.entry_index || got.entry_valid !== want.entry_valid ||
              got.entry_mac !== want.entry_mac || got.risk_score !== want.risk_score ||
              got.threat_kind !== want.threat_kind ||
              got.newly_malicious !== want.newly_malicious ||
              got.is_malicious !== want.is_malicious ||
              got.threat_total !== want.threat_total ||
              got.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                       $realtime, want, got);
          end
        end
      end
      if (frame_in.valid && frame_in.ready) predict_item(frame_in.data);
      if (cfg.valid && cfg.ready) apply_cfg(cfg.index, cfg.wdata);
    end
  end

  // Item driver.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_busy && in_fire) begin
        in_busy = 0;
        send_gap = calm ? 0 : $urandom_range(0, 16);
      end
      if (!in_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          frame_in.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          frame_in.data <= pending_items.pop_front();
          frame_in.valid <= 1'b1;
          in_busy = 1;
        end else begin
          frame_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with per-result stalls and one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_seen != hold_gen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_out.ready <= 1'b0;
      end else begin
        if (out_fire) recv_stall = calm ? 0 : $urandom_range(0, 16);
        if (recv_stall > 0) begin
          recv_stall--;
          result_out.ready <= 1'b0;
        end else begin
          result_out.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("mgmt_frame_rate_threat_tracker_core verification failed");
      $finish;
    end
  end

  function automatic mft_pkg::in_item_t frame_of(logic [47:0] mac, logic [7:0] fc,
                                                 logic [11:0] len, logic mgmt);
    mft_pkg::in_item_t it;
    it.operation = mft_pkg::OP_FRAME;
    it.source_mac = mac;
    it.frame_control = fc;
    it.frame_length = len;
    it.is_management = mgmt;
    it.now_ms = clock_ms;
    frames_sent++;
    return it;
  endfunction

  function automatic mft_pkg::in_item_t tick_at();
    mft_pkg::in_item_t it;
    it.operation = mft_pkg::OP_TICK;
    it.source_mac = 48'({$urandom, $urandom});
    it.frame_control = 8'($urandom);
    it.frame_length = 12'($urandom);
    it.is_management = 1'($urandom);
    it.now_ms = clock_ms;
    ticks_sent++;
    return it;
  endfunction

  function automatic mft_pkg::in_item_t random_item();
    int pick;
    logic [47:0] mac;
    logic [7:0] fc;
    logic [11:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 85) clock_ms += $urandom_range(0, 150);
    else if (pick < 95) clock_ms += $urandom_range(0, 9000);
    else clock_ms += $urandom_range(30000, 70000);
    if ($urandom_range(0, 9) == 0) return tick_at();
    pick = $urandom_range(0, 99);
    if (pick < 70) mac = mac_pool[$urandom_range(0, 7)];
    else if (pick < 92) mac = mac_pool[$urandom_range(0, 39)];
    else mac = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 35) fc = {mft_pkg::SUB_BEACON, 4'(mft_pkg::FTYPE_MGMT) << 2};
    else if (pick < 55) fc = {mft_pkg::SUB_PROBE, 4'(mft_pkg::FTYPE_MGMT) << 2};
    else if (pick < 75) fc = {mft_pkg::SUB_DEAUTH, 4'(mft_pkg::FTYPE_MGMT) << 2};
    else if (pick < 85)
      fc = {mft_pkg::SUB_BEACON, 2'(mft_pkg::FTYPE_MGMT), 2'($urandom)} ^ 8'h08;
    else fc = 8'($urandom);
    len = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(24, 400));
    return frame_of(mac, fc, len, $urandom_range(0, 15) != 0);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic cfg_all(int b, int p, int d, int a, int wl, int st);
    cfg_write(mft_pkg::CFG_BEACON_LIMIT, 16'(b));
    cfg_write(mft_pkg::CFG_PROBE_LIMIT, 16'(p));
    cfg_write(mft_pkg::CFG_DEAUTH_LIMIT, 16'(d));
    cfg_write(mft_pkg::CFG_ALARM_LEVEL, 16'(a));
    cfg_write(mft_pkg::CFG_WINDOW_LEN, 16'(wl));
    cfg_write(mft_pkg::CFG_STALE_AFTER, 16'(st));
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_busy && awaited_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) add_item(random_item());
  endtask

  initial begin
    limits = '{beacon_rate_limit: 8'd10, probe_rate_limit: 8'd10, deauth_rate_limit: 8'd5,
               risk_alarm_level: 5'd5, window_length_ms: 16'd5000, stale_after_ms: 16'd30000};
    foreach (used_q[i]) used_q[i] = 1'b0;
    foreach (table_q[i]) table_q[i] = '0;
    threat_count = '0;
    frame_in.valid = 1'b0;
    frame_in.data = '0;
    result_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.wdata = '0;
    in_fire = 0;
    out_fire = 0;
    clock_ms = 32'hFFFF_8000;
    mac_pool[0] = '0;
    mac_pool[1] = '1;
    for (int i = 2; i < 40; i++) mac_pool[i] = 48'({$urandom, $urandom});
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty table, drops, each subtype, type bits, bursts, window restart, stale entries.
    add_item(tick_at());
    add_item(frame_of(mac_pool[0], 8'h80, 12'd100, 1'b0));
    add_item(frame_of(mac_pool[0], 8'h80, 12'd23, 1'b1));
    add_item(frame_of(mac_pool[0], 8'h80, 12'd24, 1'b1));
    add_item(frame_of(mac_pool[1], 8'h40, 12'd4095, 1'b1));
    add_item(frame_of(mac_pool[2], 8'hC0, 12'd60, 1'b1));
    add_item(frame_of(mac_pool[2], 8'h00, 12'd60, 1'b1));
    add_item(frame_of(mac_pool[2], 8'h88, 12'd60, 1'b1));
    add_item(frame_of(mac_pool[3], 8'hFF, 12'd0, 1'b1));
    add_item(frame_of(mac_pool[3], 8'hFF, 12'd30, 1'b1));
    for (int i = 0; i < 6; i++) add_item(frame_of(mac_pool[0], 8'h80, 12'd80, 1'b1));
    for (int i = 0; i < 4; i++) add_item(frame_of(mac_pool[2], 8'hC0, 12'd40, 1'b1));
    add_item(tick_at());
    clock_ms += 32'd6000;
    add_item(tick_at());
    clock_ms += 32'd40000;
    add_item(frame_of(mac_pool[1], 8'h40, 12'd50, 1'b1));
    add_item(tick_at());
    drain();

    run_random(80);
    drain();

    // Lowest limits; the receiver holds off while the sender keeps offering.
    cfg_all(0, 0, 0, 0, 0, 0);
    run_random(20);
    hold_gen++;
    run_random(60);
    drain();

    // Highest limits, then a calm stretch with no idling.
    cfg_all(255, 255, 255, 31, 65535, 65535);
    calm = 1;
    run_random(50);
    drain();
    calm = 0;
    run_random(40);
    drain();

    cfg_all($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30),
            $urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_random(100);
    drain();
    repeat (300) @(posedge clk);

    $display("covered %0d frames and %0d ticks, %0d results checked over four limit settings",
             frames_sent, ticks_sent, results_seen);
    $display("threat count reached %0d; mismatches %0d", threat_count, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("mgmt_frame_rate_threat_tracker_core verification clean");
    else
      $display("mgmt_frame_rate_threat_tracker_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mft_pkg.sv
sv/mft_in_if.sv
sv/mft_out_if.sv
sv/mft_cfg_if.sv
sv/mft_ram.sv
sv/mft_cfg_regs.sv
sv/mft_mul.sv
sv/mgmt_frame_rate_threat_tracker_core.sv
sim/tb_top.sv
